// ===== rtl/core/periodic_timer_table_macros.svh =====
// ----------------------------------------------------------------------------
// Periodic timer table assertion macros
// Assertion wrappers used by the timer table sequencer. They compile away in
// synthesis builds.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TIMER_TABLE_MACROS_SVH
`define PERIODIC_TIMER_TABLE_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define PTT_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked outside reset.
`define PTT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PTT_ASSERT_NOW(label, clk, rstn, ante, cons, msg)
`define PTT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== rtl/core/ptt_pkg.sv =====
// ----------------------------------------------------------------------------
// Periodic timer table package
// Opcodes, status codes, sequencer states and shared types.
// ----------------------------------------------------------------------------
package ptt_pkg;

    // Fixed field widths of the stream items.
    localparam int PTT_TICK_W = 32;
    localparam int PTT_TIDX_W = 3;
    localparam int PTT_OP_W   = 3;

    // A service item reports at most this many fired timers.
    localparam int PTT_OUT_MAX = 8;
    localparam int PTT_SVC_W   = 3;

    typedef enum logic [PTT_OP_W-1:0] {
        OP_ADD     = 3'd0,
        OP_START   = 3'd1,
        OP_STOP    = 3'd2,
        OP_TICK    = 3'd3,
        OP_SERVICE = 3'd4
    } ptt_opcode_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_UNUSED = 2'd2
    } ptt_status_t;

    // Operations of the shared arithmetic unit.
    typedef enum logic [1:0] {
        ALU_ADD   = 2'd0,
        ALU_LE    = 2'd1,
        ALU_GUARD = 2'd2
    } ptt_alu_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_ADD_GUARD,
        ST_ADD_WRITE,
        ST_TICK_READ,
        ST_TICK_CMP,
        ST_TICK_GUARD,
        ST_TICK_RELOAD,
        ST_TICK_INC,
        ST_SWEEP_READ,
        ST_SWEEP_WRITE,
        ST_SVC_SCAN,
        ST_EMIT
    } ptt_state_t;

    // Control of the timer memories.
    typedef struct packed {
        logic rd_en;
        logic wr_period;
        logic wr_expiry;
    } ptt_mem_ctl_t;

endpackage

// ===== rtl/core/ptt_alu.sv =====
// ----------------------------------------------------------------------------
// Timer table arithmetic unit
// One 34-bit adder shared by the expiry reload, the expiry compare and the
// wrap guard test.
// ----------------------------------------------------------------------------
module ptt_alu #(
    parameter logic [31:0] TICK_LIMIT = 32'hFFFF_FFFF
) (
    input  ptt_pkg::ptt_alu_op_t              op,
    input  logic [ptt_pkg::PTT_TICK_W-1:0]    a,
    input  logic [ptt_pkg::PTT_TICK_W-1:0]    b,
    output logic [ptt_pkg::PTT_TICK_W-1:0]    res,
    output logic                              flag
);
    import ptt_pkg::*;

    localparam int SUM_W = PTT_TICK_W + 2;
    localparam logic [SUM_W-1:0] LIMIT_EXT = {2'b00, TICK_LIMIT};

    logic [SUM_W-1:0] opx;
    logic [SUM_W-1:0] opy;
    logic             cin;
    logic [SUM_W-1:0] sum;

    // Operand selection: add is a + b, compare is b - a, guard is 2a + b.
    always_comb begin
        opx = {2'b00, a};
        opy = {2'b00, b};
        cin = 1'b0;
        case (op)
            ALU_ADD: begin
                opx = {2'b00, a};
            end
            ALU_LE: begin
                opx = {2'b00, b};
                opy = ~{2'b00, a};
                cin = 1'b1;
            end
            ALU_GUARD: begin
                opx = {1'b0, a, 1'b0};
            end
            default: begin
                opx = {2'b00, a};
            end
        endcase
    end

    assign sum = opx + opy + SUM_W'(cin);
    assign res = sum[PTT_TICK_W-1:0];

    // Compare: a <= b when b - a does not borrow.
    // Guard: limit - tick < 2 * period is the same as tick + 2 * period > limit.
    always_comb begin
        case (op)
            ALU_LE:    flag = ~sum[SUM_W-1];
            ALU_GUARD: flag = (sum > LIMIT_EXT);
            default:   flag = 1'b0;
        endcase
    end

endmodule

// ===== rtl/core/ptt_store.sv =====
// ----------------------------------------------------------------------------
// Timer table storage
// Period and expiry memories, one shared address, registered read data.
// ----------------------------------------------------------------------------
module ptt_store #(
    parameter int TIMER_SLOTS = 8,
    parameter int IDX_W       = 3
) (
    input  logic                              aclk,
    input  ptt_pkg::ptt_mem_ctl_t             ctl,
    input  logic [IDX_W-1:0]                  addr,
    input  logic [ptt_pkg::PTT_TICK_W-1:0]    wdata_period,
    input  logic [ptt_pkg::PTT_TICK_W-1:0]    wdata_expiry,
    output logic [ptt_pkg::PTT_TICK_W-1:0]    rd_period,
    output logic [ptt_pkg::PTT_TICK_W-1:0]    rd_expiry
);
    import ptt_pkg::*;

    logic [PTT_TICK_W-1:0] period_mem [TIMER_SLOTS];
    logic [PTT_TICK_W-1:0] expiry_mem [TIMER_SLOTS];
    logic [PTT_TICK_W-1:0] rd_period_reg;
    logic [PTT_TICK_W-1:0] rd_expiry_reg;

    // Write ports.
    always_ff @(posedge aclk) begin
        if (ctl.wr_period) begin
            period_mem[addr] <= wdata_period;
        end
        if (ctl.wr_expiry) begin
            expiry_mem[addr] <= wdata_expiry;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rd_period_reg <= period_mem[addr];
            rd_expiry_reg <= expiry_mem[addr];
        end
    end

    assign rd_period = rd_period_reg;
    assign rd_expiry = rd_expiry_reg;

endmodule

// ===== rtl/core/ptt_seq.sv =====
// ----------------------------------------------------------------------------
// Timer table sequencer
// Decodes each item, walks the timer slots through the shared arithmetic
// unit and the memories, and drives the result register.
// ----------------------------------------------------------------------------
`include "periodic_timer_table_macros.svh"

module ptt_seq #(
    parameter int TIMER_SLOTS = 8,
    parameter int IDX_W       = 3,
    parameter int CNT_W       = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input item
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ptt_pkg::PTT_OP_W-1:0]      s_opcode,
    input  logic [ptt_pkg::PTT_TICK_W-1:0]    s_period,
    input  logic [ptt_pkg::PTT_TIDX_W-1:0]    s_slot,
    // Memories
    output ptt_pkg::ptt_mem_ctl_t             mem_ctl,
    output logic [IDX_W-1:0]                  mem_addr,
    output logic [ptt_pkg::PTT_TICK_W-1:0]    mem_wdata_period,
    output logic [ptt_pkg::PTT_TICK_W-1:0]    mem_wdata_expiry,
    input  logic [ptt_pkg::PTT_TICK_W-1:0]    mem_rd_period,
    input  logic [ptt_pkg::PTT_TICK_W-1:0]    mem_rd_expiry,
    // Shared arithmetic unit
    output ptt_pkg::ptt_alu_op_t              alu_op,
    output logic [ptt_pkg::PTT_TICK_W-1:0]    alu_a,
    output logic [ptt_pkg::PTT_TICK_W-1:0]    alu_b,
    input  logic [ptt_pkg::PTT_TICK_W-1:0]    alu_res,
    input  logic                              alu_flag,
    // Result item
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output ptt_pkg::ptt_status_t              m_status,
    output logic [ptt_pkg::PTT_TIDX_W-1:0]    m_timer_index,
    output logic                              m_fired_valid,
    output logic                              m_last,
    output logic [ptt_pkg::PTT_TICK_W-1:0]    m_tick_now
);
    import ptt_pkg::*;

    localparam int CMP_W = (CNT_W > PTT_TIDX_W) ? CNT_W : PTT_TIDX_W;

    // Sequencer and item registers
    ptt_state_t               state_reg,  state_next;
    ptt_state_t               ret_reg,    ret_next;
    logic [PTT_OP_W-1:0]      opcode_reg, opcode_next;
    logic [PTT_TICK_W-1:0]    arg_period_reg, arg_period_next;
    logic [PTT_TIDX_W-1:0]    slot_reg,   slot_next;
    logic [CNT_W-1:0]         walk_reg,   walk_next;
    logic [CNT_W-1:0]         sweep_reg,  sweep_next;
    logic [PTT_SVC_W-1:0]     svc_n_reg,  svc_n_next;
    ptt_status_t              emit_status_reg, emit_status_next;
    logic [PTT_TIDX_W-1:0]    emit_idx_reg,    emit_idx_next;

    // Timer state
    logic [PTT_TICK_W-1:0]    tick_reg,   tick_next;
    logic [CNT_W-1:0]         slots_used_reg, slots_used_next;
    logic [TIMER_SLOTS-1:0]   enable_reg, enable_next;
    logic [TIMER_SLOTS-1:0]   fired_reg,  fired_next;

    // Result register
    logic                     out_valid_reg;
    ptt_status_t              out_status_reg;
    logic [PTT_TIDX_W-1:0]    out_idx_reg;
    logic                     out_fired_reg;
    logic                     out_last_reg;
    logic [PTT_TICK_W-1:0]    out_tick_reg;

    logic                     out_free;
    logic                     out_load;
    ptt_status_t              load_status;
    logic [PTT_TIDX_W-1:0]    load_idx;
    logic                     load_fired;
    logic                     load_last;

    logic                     in_accept;
    logic                     slot_in_use;
    logic                     more_fired;
    logic [IDX_W-1:0]         walk_idx;
    logic [IDX_W-1:0]         sweep_idx;
    logic [IDX_W-1:0]         new_idx;
    logic [IDX_W-1:0]         slot_idx;

    assign s_tready    = (state_reg == ST_IDLE);
    assign in_accept   = s_tvalid && s_tready;
    assign out_free    = !out_valid_reg || m_tready;
    assign walk_idx    = IDX_W'(walk_reg);
    assign sweep_idx   = IDX_W'(sweep_reg);
    assign new_idx     = IDX_W'(slots_used_reg);
    assign slot_idx    = IDX_W'(slot_reg);
    assign slot_in_use = (CMP_W'(slot_reg) < CMP_W'(slots_used_reg));

    // Any flagged slot in use above the current walk position.
    always_comb begin
        more_fired = 1'b0;
        for (int k = 0; k < TIMER_SLOTS; k++) begin
            if ((CNT_W'(k) < slots_used_reg) && (CNT_W'(k) > walk_reg) && fired_reg[k]) begin
                more_fired = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            tick_reg       <= '0;
            slots_used_reg <= '0;
        end else begin
            state_reg      <= state_next;
            tick_reg       <= tick_next;
            slots_used_reg <= slots_used_next;
        end
    end

    // Working registers and per-slot bits
    always_ff @(posedge aclk) begin
        ret_reg         <= ret_next;
        opcode_reg      <= opcode_next;
        arg_period_reg  <= arg_period_next;
        slot_reg        <= slot_next;
        walk_reg        <= walk_next;
        sweep_reg       <= sweep_next;
        svc_n_reg       <= svc_n_next;
        emit_status_reg <= emit_status_next;
        emit_idx_reg    <= emit_idx_next;
        enable_reg      <= enable_next;
        fired_reg       <= fired_next;
    end

    // Next state and datapath control
    always_comb begin
        state_next       = state_reg;
        ret_next         = ret_reg;
        opcode_next      = opcode_reg;
        arg_period_next  = arg_period_reg;
        slot_next        = slot_reg;
        walk_next        = walk_reg;
        sweep_next       = sweep_reg;
        svc_n_next       = svc_n_reg;
        emit_status_next = emit_status_reg;
        emit_idx_next    = emit_idx_reg;
        tick_next        = tick_reg;
        slots_used_next  = slots_used_reg;
        enable_next      = enable_reg;
        fired_next       = fired_reg;

        mem_ctl          = '0;
        mem_addr         = walk_idx;
        mem_wdata_period = arg_period_reg;
        mem_wdata_expiry = alu_res;

        alu_op           = ALU_ADD;
        alu_a            = arg_period_reg;
        alu_b            = tick_reg;

        out_load         = 1'b0;
        load_status      = emit_status_reg;
        load_idx         = emit_idx_reg;
        load_fired       = 1'b0;
        load_last        = 1'b1;

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    opcode_next     = s_opcode;
                    arg_period_next = s_period;
                    slot_next       = s_slot;
                    state_next      = ST_DISPATCH;
                end
            end

            ST_DISPATCH: begin
                emit_status_next = STAT_OK;
                emit_idx_next    = '0;
                walk_next        = '0;
                svc_n_next       = '0;
                case (opcode_reg)
                    OP_ADD: begin
                        if (slots_used_reg == CNT_W'(TIMER_SLOTS)) begin
                            emit_status_next = STAT_FULL;
                            state_next       = ST_EMIT;
                        end else begin
                            enable_next[new_idx] = 1'b0;
                            fired_next[new_idx]  = 1'b0;
                            state_next           = ST_ADD_GUARD;
                        end
                    end
                    OP_START, OP_STOP: begin
                        if (slot_in_use) begin
                            enable_next[slot_idx] = (opcode_reg == OP_START);
                        end else begin
                            emit_status_next = STAT_UNUSED;
                        end
                        state_next = ST_EMIT;
                    end
                    OP_TICK: begin
                        state_next = ST_TICK_READ;
                    end
                    OP_SERVICE: begin
                        state_next = ST_SVC_SCAN;
                    end
                    default: begin
                        state_next = ST_EMIT;
                    end
                endcase
            end

            // Wrap guard ahead of the new timer's expiry.
            ST_ADD_GUARD: begin
                alu_op = ALU_GUARD;
                if (alu_flag) begin
                    tick_next  = '0;
                    sweep_next = '0;
                    ret_next   = ST_ADD_WRITE;
                    state_next = ST_SWEEP_READ;
                end else begin
                    state_next = ST_ADD_WRITE;
                end
            end

            // Store period and first expiry in the next free slot.
            ST_ADD_WRITE: begin
                alu_op              = ALU_ADD;
                mem_addr            = new_idx;
                mem_ctl.wr_period   = 1'b1;
                mem_ctl.wr_expiry   = 1'b1;
                slots_used_next     = slots_used_reg + 1'b1;
                emit_idx_next       = PTT_TIDX_W'(new_idx);
                state_next          = ST_EMIT;
            end

            ST_TICK_READ: begin
                if (walk_reg == slots_used_reg) begin
                    state_next = ST_TICK_INC;
                end else begin
                    mem_ctl.rd_en = 1'b1;
                    state_next    = ST_TICK_CMP;
                end
            end

            // Expiry compare against the current tick.
            ST_TICK_CMP: begin
                alu_op          = ALU_LE;
                alu_a           = mem_rd_expiry;
                arg_period_next = mem_rd_period;
                if (enable_reg[walk_idx] && alu_flag) begin
                    fired_next[walk_idx] = 1'b1;
                    state_next           = ST_TICK_GUARD;
                end else begin
                    walk_next  = walk_reg + 1'b1;
                    state_next = ST_TICK_READ;
                end
            end

            ST_TICK_GUARD: begin
                alu_op = ALU_GUARD;
                if (alu_flag) begin
                    tick_next  = '0;
                    sweep_next = '0;
                    ret_next   = ST_TICK_RELOAD;
                    state_next = ST_SWEEP_READ;
                end else begin
                    state_next = ST_TICK_RELOAD;
                end
            end

            ST_TICK_RELOAD: begin
                alu_op            = ALU_ADD;
                mem_ctl.wr_expiry = 1'b1;
                walk_next         = walk_reg + 1'b1;
                state_next        = ST_TICK_READ;
            end

            ST_TICK_INC: begin
                alu_op     = ALU_ADD;
                alu_a      = PTT_TICK_W'(1);
                tick_next  = alu_res;
                state_next = ST_EMIT;
            end

            // Wrap: every used slot restarts from its period.
            ST_SWEEP_READ: begin
                mem_addr = sweep_idx;
                if (sweep_reg == slots_used_reg) begin
                    state_next = ret_reg;
                end else begin
                    mem_ctl.rd_en = 1'b1;
                    state_next    = ST_SWEEP_WRITE;
                end
            end

            ST_SWEEP_WRITE: begin
                mem_addr          = sweep_idx;
                mem_ctl.wr_expiry = 1'b1;
                mem_wdata_expiry  = mem_rd_period;
                sweep_next        = sweep_reg + 1'b1;
                state_next        = ST_SWEEP_READ;
            end

            // Report flagged slots, lowest first, one item per flagged slot, at most PTT_OUT_MAX.
            ST_SVC_SCAN: begin
                if (walk_reg == slots_used_reg) begin
                    state_next = (svc_n_reg == '0) ? ST_EMIT : ST_IDLE;
                end else if (fired_reg[walk_idx]) begin
                    if (out_free) begin
                        out_load             = 1'b1;
                        load_status          = STAT_OK;
                        load_idx             = PTT_TIDX_W'(walk_idx);
                        load_fired           = 1'b1;
                        load_last            = (svc_n_reg == PTT_SVC_W'(PTT_OUT_MAX - 1))
                                               || !more_fired;
                        fired_next[walk_idx] = 1'b0;
                        svc_n_next           = svc_n_reg + 1'b1;
                        walk_next            = walk_reg + 1'b1;
                        if (load_last) begin
                            state_next = ST_IDLE;
                        end
                    end
                end else begin
                    walk_next = walk_reg + 1'b1;
                end
            end

            ST_EMIT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result register: holds one item until it is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_status_reg <= load_status;
            out_idx_reg    <= load_idx;
            out_fired_reg  <= load_fired;
            out_last_reg   <= load_last;
            out_tick_reg   <= tick_reg;
        end
    end

    assign m_tvalid      = out_valid_reg;
    assign m_status      = out_status_reg;
    assign m_timer_index = out_idx_reg;
    assign m_fired_valid = out_fired_reg;
    assign m_last        = out_last_reg;
    assign m_tick_now    = out_tick_reg;

    // Checks on the sequencer.
    `PTT_ASSERT_NOW(a_slots_bound, aclk, aresetn, 1'b1, slots_used_reg <= CNT_W'(TIMER_SLOTS), "slot count above table size")
    `PTT_ASSERT_NOW(a_load_free, aclk, aresetn, out_load, !out_valid_reg || m_tready, "result register overwritten")
    `PTT_ASSERT_NEXT(a_accept_busy, aclk, aresetn, in_accept, state_reg == ST_DISPATCH, "accepted item not dispatched")
    `PTT_ASSERT_NOW(a_sweep_bound, aclk, aresetn, state_reg == ST_SWEEP_WRITE, sweep_reg < slots_used_reg, "sweep past used slots")

endmodule

// ===== rtl/core/periodic_timer_table.sv =====
// ----------------------------------------------------------------------------
// Periodic timer table
// Up to TIMER_SLOTS periodic timers sharing one tick counter, with add,
// start, stop, tick and service commands.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata (low bit up)                 | tuser       | tlast
//  s_       | in        | period_ticks[31:0], slot_index[2:0] | opcode[2:0] | -
//  m_       | out       | status[1:0], timer_index[2:0],      | fired_valid | last
//           |           | tick_now[31:0]                      |             |
//
// A tick walks the N used slots and reloads each timer that fires. An add or a
// tick also sweeps the table whenever the wrap guard restarts it. A service
// scans the used slots. The single memory read port sets the walk speed.
// Reset clears the tick counter, the slot count and the sequencer; the
// memories need no clearing pass. The next item is taken once the last
// result of the current one sits in the output register; a stalled m_
// channel holds the sequencer before each further result.
// ----------------------------------------------------------------------------
module periodic_timer_table #(
    parameter int          TIMER_SLOTS = 8,
    parameter logic [31:0] TICK_LIMIT  = 32'hFFFF_FFFF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // period_ticks[31:0], slot_index[34:32]
    input  logic [2:0]  s_tuser,   // opcode[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // status[1:0], timer_index[4:2], tick_now[36:5]
    output logic [0:0]  m_tuser,   // fired_valid[0]
    output logic        m_tlast
);
    import ptt_pkg::*;

    localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CNT_W = $clog2(TIMER_SLOTS + 1);

    ptt_mem_ctl_t            mem_ctl;
    logic [IDX_W-1:0]        mem_addr;
    logic [PTT_TICK_W-1:0]   mem_wdata_period;
    logic [PTT_TICK_W-1:0]   mem_wdata_expiry;
    logic [PTT_TICK_W-1:0]   mem_rd_period;
    logic [PTT_TICK_W-1:0]   mem_rd_expiry;
    ptt_alu_op_t             alu_op;
    logic [PTT_TICK_W-1:0]   alu_a;
    logic [PTT_TICK_W-1:0]   alu_b;
    logic [PTT_TICK_W-1:0]   alu_res;
    logic                    alu_flag;
    ptt_status_t             out_status;
    logic [PTT_TIDX_W-1:0]   out_idx;
    logic                    out_fired;
    logic [PTT_TICK_W-1:0]   out_tick;

    ptt_seq #(
        .TIMER_SLOTS (TIMER_SLOTS),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_seq (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_opcode         (s_tuser),
        .s_period         (s_tdata[31:0]),
        .s_slot           (s_tdata[34:32]),
        .mem_ctl          (mem_ctl),
        .mem_addr         (mem_addr),
        .mem_wdata_period (mem_wdata_period),
        .mem_wdata_expiry (mem_wdata_expiry),
        .mem_rd_period    (mem_rd_period),
        .mem_rd_expiry    (mem_rd_expiry),
        .alu_op           (alu_op),
        .alu_a            (alu_a),
        .alu_b            (alu_b),
        .alu_res          (alu_res),
        .alu_flag         (alu_flag),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_status         (out_status),
        .m_timer_index    (out_idx),
        .m_fired_valid    (out_fired),
        .m_last           (m_tlast),
        .m_tick_now       (out_tick)
    );

    ptt_alu #(
        .TICK_LIMIT (TICK_LIMIT)
    ) u_alu (
        .op   (alu_op),
        .a    (alu_a),
        .b    (alu_b),
        .res  (alu_res),
        .flag (alu_flag)
    );

    ptt_store #(
        .TIMER_SLOTS (TIMER_SLOTS),
        .IDX_W       (IDX_W)
    ) u_store (
        .aclk         (aclk),
        .ctl          (mem_ctl),
        .addr         (mem_addr),
        .wdata_period (mem_wdata_period),
        .wdata_expiry (mem_wdata_expiry),
        .rd_period    (mem_rd_period),
        .rd_expiry    (mem_rd_expiry)
    );

    // Result packing.
    assign m_tdata = {3'b000, out_tick, out_idx, out_status};
    assign m_tuser = out_fired;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic timer table testbench
// Drives add, start, stop, tick, service and undefined commands into the
// timer table. A behavioral copy of the table predicts every result item,
// and a monitor compares each result with the oldest prediction. Both
// stream sides idle at random, and the result side holds off once for a
// long stretch so that the table backs up into its input.
// ----------------------------------------------------------------------------
module testbench;
    import ptt_pkg::*;

    localparam int          SLOTS         = 8;
    localparam logic [31:0] LIMIT_TICK    = 32'hFFFF_FFFF;
    localparam int          RANDOM_ITEMS  = 420;
    localparam int          CYCLE_LIMIT   = 600000;
    localparam int          SETTLE_CYCLES = 60;
    localparam int          HOLD_CYCLES   = 300;

    // Opcodes the table does not define; it answers them with a plain ok.
    localparam logic [2:0] OP_UNDEF_FIRST = 3'd5;
    localparam logic [2:0] OP_UNDEF_LAST  = 3'd7;

    typedef struct {
        logic [2:0]  opcode;
        logic [31:0] period;
        logic [2:0]  slot;
    } timer_cmd_t;

    typedef struct {
        ptt_status_t status;
        logic [2:0]  index;
        logic        fired;
        logic        last;
        logic [31:0] tick;
    } timer_report_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    timer_cmd_t    pending_cmds[$];
    timer_report_t expected_reports[$];
    timer_cmd_t    bus_cmd;

    int items_sent   = 0;
    int total_items  = 0;
    int reports_seen = 0;
    int fail_count   = 0;
    int cycle_count  = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;

    // Behavioral copy of the timer table.
    logic [31:0] tick_cnt = '0;
    int          used_cnt = 0;
    logic [31:0] period_mem[SLOTS];
    logic [31:0] expiry_mem[SLOTS];
    logic        enabled[SLOTS];
    logic        flagged[SLOTS];

    periodic_timer_table #(
        .TIMER_SLOTS(SLOTS),
        .TICK_LIMIT (LIMIT_TICK)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    // Clock generation.
    initial begin
        forever #5 aclk = ~aclk;
    end

    // Restart the table when the room left below the limit is less than
    // twice the period. A tick already past the limit leaves negative room,
    // so the test is made as tick plus twice the period against the limit.
    function automatic void guard_wrap(logic [31:0] period);
        logic [33:0] reach;
        reach = {2'b00, tick_cnt} + {1'b0, period, 1'b0};
        if (reach > {2'b00, LIMIT_TICK}) begin
            tick_cnt = '0;
            for (int i = 0; i < used_cnt; i++) begin
                expiry_mem[i] = period_mem[i];
            end
        end
    endfunction

    function automatic void post_report(ptt_status_t status, logic [2:0] index,
                                        logic fired, logic last);
        timer_report_t rep;
        rep.status = status;
        rep.index  = index;
        rep.fired  = fired;
        rep.last   = last;
        rep.tick   = tick_cnt;
        expected_reports.push_back(rep);
    endfunction

    // Apply one accepted command to the table copy and queue its results.
    function automatic void apply_timer_cmd(timer_cmd_t cmd);
        int fired_slots[$];
        int s;
        case (cmd.opcode)
            OP_ADD: begin
                if (used_cnt < SLOTS) begin
                    s = used_cnt;
                    enabled[s] = 1'b0;
                    flagged[s] = 1'b0;
                    guard_wrap(cmd.period);
                    period_mem[s] = cmd.period;
                    expiry_mem[s] = cmd.period + tick_cnt;
                    used_cnt = s + 1;
                    post_report(STAT_OK, s[2:0], 1'b0, 1'b1);
                end else begin
                    post_report(STAT_FULL, '0, 1'b0, 1'b1);
                end
            end
            OP_START, OP_STOP: begin
                if (int'(cmd.slot) < used_cnt) begin
                    enabled[cmd.slot] = (cmd.opcode == OP_START);
                    post_report(STAT_OK, '0, 1'b0, 1'b1);
                end else begin
                    post_report(STAT_UNUSED, '0, 1'b0, 1'b1);
                end
            end
            OP_TICK: begin
                for (int i = 0; i < used_cnt; i++) begin
                    if (enabled[i] && expiry_mem[i] <= tick_cnt) begin
                        flagged[i] = 1'b1;
                        guard_wrap(period_mem[i]);
                        expiry_mem[i] = period_mem[i] + tick_cnt;
                    end
                end
                tick_cnt = tick_cnt + 32'd1;
                post_report(STAT_OK, '0, 1'b0, 1'b1);
            end
            OP_SERVICE: begin
                for (int i = 0; i < used_cnt && fired_slots.size() < PTT_OUT_MAX; i++) begin
                    if (flagged[i]) begin
                        flagged[i] = 1'b0;
                        fired_slots.push_back(i);
                    end
                end
                if (fired_slots.size() == 0) begin
                    post_report(STAT_OK, '0, 1'b0, 1'b1);
                end
                for (int k = 0; k < fired_slots.size(); k++) begin
                    s = fired_slots[k];
                    post_report(STAT_OK, s[2:0], 1'b1, k == fired_slots.size() - 1);
                end
            end
            default: begin
                post_report(STAT_OK, '0, 1'b0, 1'b1);
            end
        endcase
    endfunction

    function automatic void queue_cmd(logic [2:0] opcode, logic [31:0] period,
                                      logic [2:0] slot);
        timer_cmd_t cmd;
        cmd.opcode = opcode;
        cmd.period = period;
        cmd.slot   = slot;
        pending_cmds.push_back(cmd);
    endfunction

    // Random commands: mostly ticks, services and enables, with rare adds so
    // that the table fills slowly over the run.
    function automatic timer_cmd_t random_cmd();
        timer_cmd_t cmd;
        int pick;
        int sel;
        pick = $urandom_range(99);
        sel  = $urandom_range(99);
        cmd.period = $urandom;
        cmd.slot   = 3'($urandom_range(7));
        if (pick < 4) begin
            cmd.opcode = OP_ADD;
            if (sel < 80) begin
                cmd.period = 32'($urandom_range(6));
            end else if (sel < 90) begin
                cmd.period = 32'h8000_0000 | $urandom;
            end
        end else if (pick < 24) begin
            cmd.opcode = OP_START;
        end else if (pick < 31) begin
            cmd.opcode = OP_STOP;
        end else if (pick < 66) begin
            cmd.opcode = OP_TICK;
        end else if (pick < 92) begin
            cmd.opcode = OP_SERVICE;
        end else begin
            cmd.opcode = 3'($urandom_range(OP_UNDEF_LAST, OP_UNDEF_FIRST));
        end
        return cmd;
    endfunction

    // Stimulus, reset and end of run.
    initial begin
        // Empty table: nothing to service, an idle tick, unused slots.
        queue_cmd(OP_SERVICE, '0, '0);
        queue_cmd(OP_TICK, '0, '0);
        queue_cmd(OP_START, '0, 3'd0);
        queue_cmd(OP_STOP, '0, 3'd7);
        queue_cmd(OP_UNDEF_FIRST, '0, '0);
        // Two short timers that fire, then a service that reports both.
        queue_cmd(OP_ADD, 32'd0, '0);
        queue_cmd(OP_ADD, 32'd2, '0);
        queue_cmd(OP_START, '0, 3'd0);
        queue_cmd(OP_START, '0, 3'd1);
        repeat (4) queue_cmd(OP_TICK, '0, '0);
        queue_cmd(OP_SERVICE, '0, '0);
        // The largest period forces the wrap guard to restart the table.
        queue_cmd(OP_ADD, 32'hFFFF_FFFF, '0);
        queue_cmd(OP_TICK, '0, '0);
        queue_cmd(OP_STOP, '0, 3'd0);
        queue_cmd(OP_SERVICE, '0, '0);
        queue_cmd(OP_UNDEF_FIRST + 3'd1, '0, '0);
        queue_cmd(OP_UNDEF_LAST, 32'hFFFF_FFFF, 3'd7);
        queue_cmd(OP_START, 32'hFFFF_FFFF, 3'd7);
        queue_cmd(OP_SERVICE, '0, '0);
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            pending_cmds.push_back(random_cmd());
        end
        total_items = pending_cmds.size();

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Every item accepted and every predicted result checked.
        while (items_sent < total_items || expected_reports.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Run limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("Run limit reached with %0d results still expected",
                   expected_reports.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Input driver: predicts each accepted item, then offers the next one
    // unless it idles this cycle.
    always @(posedge aclk) begin : drive_proc
        logic idle;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_timer_cmd(bus_cmd);
                items_sent <= items_sent + 1;
            end
            if (!s_tvalid || s_tready) begin
                idle = !(items_sent >= 180 && items_sent < 260) && ($urandom_range(99) < 37);
                if (pending_cmds.size() > 0 && !idle) begin
                    bus_cmd = pending_cmds.pop_front();
                    s_tdata  <= {5'b0, bus_cmd.slot, bus_cmd.period};
                    s_tuser  <= bus_cmd.opcode;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result side back-pressure, with one long hold-off early in the run.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (!hold_done && reports_seen >= 40) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (reports_seen >= 220 && reports_seen < 330) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= 37);
        end
    end

    // Result monitor: each accepted item is checked against the oldest
    // prediction, field by field.
    always @(posedge aclk) begin : check_proc
        timer_report_t want;
        logic [1:0]    got_status;
        logic [2:0]    got_index;
        logic [31:0]   got_tick;
        if (aresetn && m_tvalid && m_tready) begin
            reports_seen <= reports_seen + 1;
            got_status = m_tdata[1:0];
            got_index  = m_tdata[4:2];
            got_tick   = m_tdata[36:5];
            if (expected_reports.size() == 0) begin
                $error("Result item arrived with no result expected");
                fail_count++;
            end else begin
                want = expected_reports.pop_front();
                if (got_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, got_status);
                    fail_count++;
                end
                if (got_index !== want.index) begin
                    $error("timer_index: expected %0d, actual %0d", want.index, got_index);
                    fail_count++;
                end
                if (m_tuser[0] !== want.fired) begin
                    $error("fired_valid: expected %0d, actual %0d", want.fired, m_tuser[0]);
                    fail_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, m_tlast);
                    fail_count++;
                end
                if (got_tick !== want.tick) begin
                    $error("tick_now: expected %0d, actual %0d", want.tick, got_tick);
                    fail_count++;
                end
            end
        end
    end

endmodule
